FILE: sv/rgf_pkg.sv
`timescale 1ns / 1ps
// rgf_pkg: shared constants, register codes, request and stage structs
package rgf_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int QUO_BITS      = 32;

  // configuration register indexes
  localparam logic [1:0] CFG_GRAV_X = 2'd0;
  localparam logic [1:0] CFG_GRAV_Y = 2'd1;
  localparam logic [1:0] CFG_GRAV_Z = 2'd2;

  // clamp for intermediate products, 2^61
  localparam logic [61:0] ICAP = {1'b1, 61'd0};

  typedef struct packed {
    logic [2:0][47:0] force_in;
    logic             last;
  } side_t;

  typedef struct packed {
    logic [2:0][31:0] gbr;
    logic [31:0]      gamma;
    logic [31:0]      mass;
    side_t            side;
  } req_t;

  typedef struct packed {
    logic [2:0][31:0] qm;
    logic [2:0]       neg;
    logic [31:0]      gam;
    logic [31:0]      mass;
    side_t            side;
  } div_out_t;

  typedef struct packed {
    logic [47:0]      onep;
    logic [47:0]      gm;
    logic [47:0]      bdg_mag;
    logic             bdg_neg;
    logic [2:0][31:0] qm;
    logic [2:0]       neg;
    side_t            side;
  } dot_out_t;

  typedef struct packed {
    logic [2:0][63:0] term;
    logic [47:0]      gm;
    logic             sat;
    side_t            side;
  } term_out_t;

  typedef struct packed {
    logic [2:0][47:0] force_out;
    logic             saturated;
    logic             last;
  } res_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? 32'd0 - v : v;
  endfunction

endpackage

FILE: sv/rgf_in_if.sv
`timescale 1ns / 1ps
// rgf_in_if: particle request channel
interface rgf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] gbr_x;
  logic signed [31:0] gbr_y;
  logic signed [31:0] gbr_z;
  logic [31:0]        gamma;
  logic [31:0]        mass;
  logic signed [47:0] force_x_in;
  logic signed [47:0] force_y_in;
  logic signed [47:0] force_z_in;
  logic               last_particle;

  modport source (output valid, gbr_x, gbr_y, gbr_z, gamma, mass,
                  force_x_in, force_y_in, force_z_in, last_particle,
                  input ready);
  modport sink (input valid, gbr_x, gbr_y, gbr_z, gamma, mass,
                force_x_in, force_y_in, force_z_in, last_particle,
                output ready);
endinterface

FILE: sv/rgf_out_if.sv
`timescale 1ns / 1ps
// rgf_out_if: force result channel
interface rgf_out_if;
  logic               valid;
  logic               ready;
  logic signed [47:0] force_x_out;
  logic signed [47:0] force_y_out;
  logic signed [47:0] force_z_out;
  logic               saturated;
  logic               last;

  modport source (output valid, force_x_out, force_y_out, force_z_out, saturated, last,
                  input ready);
  modport sink (input valid, force_x_out, force_y_out, force_z_out, saturated, last,
                output ready);
endinterface

FILE: sv/rgf_cfg_if.sv
`timescale 1ns / 1ps
// rgf_cfg_if: register write channel
interface rgf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/rgf_div.sv
`timescale 1ns / 1ps
// rgf_div: pipelined restoring divider forming beta magnitudes, one quotient bit a stage
module rgf_div #(
  parameter int FRAC_BITS = rgf_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                up_valid,
  output logic                up_ready,
  input  rgf_pkg::req_t       up_data,
  output logic                dn_valid,
  input  logic                dn_ready,
  output rgf_pkg::div_out_t   dn_data
);

  localparam int QW = rgf_pkg::QUO_BITS;
  localparam int NS = QW + 1;
  localparam int NW = QW + FRAC_BITS;
  localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

  typedef struct packed {
    logic [2:0][31:0] rem;
    logic [2:0][31:0] low;
    logic [2:0]       neg;
    logic [31:0]      gam;
    logic [31:0]      mass;
    rgf_pkg::side_t   side;
  } dstage_t;

  dstage_t    st_r [NS];
  dstage_t    prep_nxt;
  logic [NS-1:0] v_r;
  logic [NS-1:0] ce;

  always_comb begin
    ce[NS-1] = !v_r[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) ce[k] = !v_r[k] || ce[k+1];
  end

  assign up_ready = ce[0];
  assign dn_valid = v_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ce[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (ce[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // gamma under one counts as one; dividend is |gbr| << frac
  always_comb begin
    logic [NW-1:0] num;
    logic [31:0]   mag;
    prep_nxt.gam  = (up_data.gamma < ONE) ? ONE : up_data.gamma;
    prep_nxt.mass = up_data.mass;
    prep_nxt.side = up_data.side;
    for (int i = 0; i < 3; i++) begin
      mag = rgf_pkg::abs32(up_data.gbr[i]);
      num = {mag, {FRAC_BITS{1'b0}}};
      prep_nxt.neg[i] = up_data.gbr[i][31];
      prep_nxt.rem[i] = 32'(num >> QW);
      prep_nxt.low[i] = num[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce[0]) st_r[0] <= prep_nxt;
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    dstage_t st_nxt;

    always_comb begin
      logic [32:0] t;
      logic        ge;
      st_nxt = st_r[k-1];
      for (int i = 0; i < 3; i++) begin
        t  = {st_r[k-1].rem[i], st_r[k-1].low[i][31]};
        ge = t >= {1'b0, st_r[k-1].gam};
        st_nxt.rem[i] = ge ? 32'(t - {1'b0, st_r[k-1].gam}) : t[31:0];
        st_nxt.low[i] = {st_r[k-1].low[i][30:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (ce[k]) st_r[k] <= st_nxt;
    end
  end

  always_comb begin
    dn_data.qm   = st_r[NS-1].low;
    dn_data.neg  = st_r[NS-1].neg;
    dn_data.gam  = st_r[NS-1].gam;
    dn_data.mass = st_r[NS-1].mass;
    dn_data.side = st_r[NS-1].side;
  end

endmodule

FILE: sv/rgf_dot.sv
`timescale 1ns / 1ps
// rgf_dot: beta squared, beta dot g and gamma times mass, three stages
module rgf_dot #(
  parameter int FRAC_BITS = rgf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0][31:0]   grav,
  input  logic               up_valid,
  output logic               up_ready,
  input  rgf_pkg::div_out_t  up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rgf_pkg::dot_out_t  dn_data
);

  localparam int NS = 3;
  localparam logic [47:0] ONE48 = 48'd1 << FRAC_BITS;

  typedef struct packed {
    logic [2:0][63:0] sq;
    logic [2:0][63:0] bg;
    logic [2:0]       bg_neg;
    logic [63:0]      gmp;
    logic [2:0][31:0] qm;
    logic [2:0]       neg;
    rgf_pkg::side_t   side;
  } pa_t;

  typedef struct packed {
    logic [47:0]      onep;
    logic [47:0]      gm;
    logic [48:0]      bdg;
    logic [2:0][31:0] qm;
    logic [2:0]       neg;
    rgf_pkg::side_t   side;
  } pb_t;

  pa_t a_r, a_nxt;
  pb_t b_r, b_nxt;
  rgf_pkg::dot_out_t c_r, c_nxt;
  logic [NS-1:0] v_r;
  logic [NS-1:0] ce;

  always_comb begin
    ce[NS-1] = !v_r[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) ce[k] = !v_r[k] || ce[k+1];
  end

  assign up_ready = ce[0];
  assign dn_valid = v_r[NS-1];
  assign dn_data  = c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ce[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (ce[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // products
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_nxt.sq[i]     = 64'(up_data.qm[i]) * 64'(up_data.qm[i]);
      a_nxt.bg[i]     = 64'(rgf_pkg::abs32(grav[i])) * 64'(up_data.qm[i]);
      a_nxt.bg_neg[i] = grav[i][31] ^ up_data.neg[i];
    end
    a_nxt.gmp  = 64'(up_data.gam) * 64'(up_data.mass);
    a_nxt.qm   = up_data.qm;
    a_nxt.neg  = up_data.neg;
    a_nxt.side = up_data.side;
  end

  // truncated sums
  always_comb begin
    logic [48:0] beta2;
    logic [48:0] part;
    beta2 = '0;
    b_nxt.bdg = '0;
    for (int i = 0; i < 3; i++) begin
      beta2 = beta2 + 49'(a_r.sq[i] >> FRAC_BITS);
      part  = 49'(a_r.bg[i] >> 16);
      b_nxt.bdg = a_r.bg_neg[i] ? b_nxt.bdg - part : b_nxt.bdg + part;
    end
    b_nxt.onep = 48'(49'(ONE48) + beta2);
    b_nxt.gm   = a_r.gmp[63:16];
    b_nxt.qm   = a_r.qm;
    b_nxt.neg  = a_r.neg;
    b_nxt.side = a_r.side;
  end

  // sign and magnitude of beta dot g
  always_comb begin
    c_nxt.onep    = b_r.onep;
    c_nxt.gm      = b_r.gm;
    c_nxt.bdg_neg = b_r.bdg[48];
    c_nxt.bdg_mag = 48'(b_r.bdg[48] ? 49'd0 - b_r.bdg : b_r.bdg);
    c_nxt.qm      = b_r.qm;
    c_nxt.neg     = b_r.neg;
    c_nxt.side    = b_r.side;
  end

  always_ff @(posedge clk) begin
    if (ce[0]) a_r <= a_nxt;
    if (ce[1]) b_r <= b_nxt;
    if (ce[2]) c_r <= c_nxt;
  end

endmodule

FILE: sv/rgf_term.sv
`timescale 1ns / 1ps
// rgf_term: per-axis (1+beta^2)*g - (beta.g)*beta with clamped products
module rgf_term #(
  parameter int FRAC_BITS = rgf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0][31:0]   grav,
  input  logic               up_valid,
  output logic               up_ready,
  input  rgf_pkg::dot_out_t  up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rgf_pkg::term_out_t dn_data
);

  localparam int NS = 3;
  localparam int PW = 80;

  typedef struct packed {
    logic [2:0][63:0] alo;
    logic [2:0][47:0] ahi;
    logic [2:0][63:0] blo;
    logic [2:0][47:0] bhi;
    logic [2:0]       aneg;
    logic [2:0]       bneg;
    logic [47:0]      gm;
    rgf_pkg::side_t   side;
  } p1_t;

  typedef struct packed {
    logic [2:0][61:0] am;
    logic [2:0][61:0] bm;
    logic [2:0]       aneg;
    logic [2:0]       bneg;
    logic [47:0]      gm;
    logic             sat;
    rgf_pkg::side_t   side;
  } p2_t;

  p1_t p1_r, p1_nxt;
  p2_t p2_r, p2_nxt;
  rgf_pkg::term_out_t p3_r, p3_nxt;
  logic [NS-1:0] v_r;
  logic [NS-1:0] ce;

  always_comb begin
    ce[NS-1] = !v_r[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) ce[k] = !v_r[k] || ce[k+1];
  end

  assign up_ready = ce[0];
  assign dn_valid = v_r[NS-1];
  assign dn_data  = p3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ce[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (ce[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // partial products, wide operand split at bit 32
  always_comb begin
    logic [31:0] gmag;
    for (int i = 0; i < 3; i++) begin
      gmag = rgf_pkg::abs32(grav[i]);
      p1_nxt.alo[i]  = 64'(up_data.onep[31:0]) * 64'(gmag);
      p1_nxt.ahi[i]  = 48'(up_data.onep[47:32]) * 48'(gmag);
      p1_nxt.blo[i]  = 64'(up_data.bdg_mag[31:0]) * 64'(up_data.qm[i]);
      p1_nxt.bhi[i]  = 48'(up_data.bdg_mag[47:32]) * 48'(up_data.qm[i]);
      p1_nxt.aneg[i] = grav[i][31];
      p1_nxt.bneg[i] = up_data.bdg_neg ^ up_data.neg[i];
    end
    p1_nxt.gm   = up_data.gm;
    p1_nxt.side = up_data.side;
  end

  // join, scale down and clamp to 2^61
  always_comb begin
    logic [PW-1:0] aq;
    logic [PW-1:0] bq;
    p2_nxt.sat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      aq = (PW'(p1_r.alo[i]) + (PW'(p1_r.ahi[i]) << 32)) >> 16;
      bq = (PW'(p1_r.blo[i]) + (PW'(p1_r.bhi[i]) << 32)) >> FRAC_BITS;
      if (aq > PW'(rgf_pkg::ICAP)) begin
        p2_nxt.am[i] = rgf_pkg::ICAP;
        p2_nxt.sat   = 1'b1;
      end else begin
        p2_nxt.am[i] = aq[61:0];
      end
      if (bq > PW'(rgf_pkg::ICAP)) begin
        p2_nxt.bm[i] = rgf_pkg::ICAP;
        p2_nxt.sat   = 1'b1;
      end else begin
        p2_nxt.bm[i] = bq[61:0];
      end
    end
    p2_nxt.aneg = p1_r.aneg;
    p2_nxt.bneg = p1_r.bneg;
    p2_nxt.gm   = p1_r.gm;
    p2_nxt.side = p1_r.side;
  end

  // signed difference
  always_comb begin
    logic [63:0] sa;
    logic [63:0] sb;
    for (int i = 0; i < 3; i++) begin
      sa = p2_r.aneg[i] ? 64'd0 - 64'(p2_r.am[i]) : 64'(p2_r.am[i]);
      sb = p2_r.bneg[i] ? 64'd0 - 64'(p2_r.bm[i]) : 64'(p2_r.bm[i]);
      p3_nxt.term[i] = sa - sb;
    end
    p3_nxt.gm   = p2_r.gm;
    p3_nxt.sat  = p2_r.sat;
    p3_nxt.side = p2_r.side;
  end

  always_ff @(posedge clk) begin
    if (ce[0]) p1_r <= p1_nxt;
    if (ce[1]) p2_r <= p2_nxt;
    if (ce[2]) p3_r <= p3_nxt;
  end

endmodule

FILE: sv/rgf_scale.sv
`timescale 1ns / 1ps
// rgf_scale: gamma*m scaling, accumulate and 48-bit saturation, ends in the output register
module rgf_scale #(
  parameter int FRAC_BITS = rgf_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  rgf_pkg::term_out_t up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rgf_pkg::res_t      dn_data
);

  localparam int NS = 6;
  localparam int PW = 111;
  localparam logic signed [63:0] FMAX = 64'sd140737488355327;
  localparam logic signed [63:0] FMIN = -64'sd140737488355328;

  typedef struct packed {
    logic [2:0][62:0] tm;
    logic [2:0]       tneg;
    logic [47:0]      gm;
    logic             sat;
    rgf_pkg::side_t   side;
  } s1_t;

  typedef struct packed {
    logic [2:0][63:0] p00;
    logic [2:0][62:0] p01;
    logic [2:0][47:0] p10;
    logic [2:0][46:0] p11;
    logic [2:0]       tneg;
    logic             sat;
    rgf_pkg::side_t   side;
  } s2_t;

  typedef struct packed {
    logic [2:0][PW-1:0] full;
    logic [2:0]         tneg;
    logic               sat;
    rgf_pkg::side_t     side;
  } s3_t;

  typedef struct packed {
    logic [2:0][61:0] dm;
    logic [2:0]       tneg;
    logic             sat;
    rgf_pkg::side_t   side;
  } s4_t;

  typedef struct packed {
    logic [2:0][63:0] sum;
    logic             sat;
    logic             last;
  } s5_t;

  s1_t s1_r, s1_nxt;
  s2_t s2_r, s2_nxt;
  s3_t s3_r, s3_nxt;
  s4_t s4_r, s4_nxt;
  s5_t s5_r, s5_nxt;
  rgf_pkg::res_t s6_r, s6_nxt;
  logic [NS-1:0] v_r;
  logic [NS-1:0] ce;

  always_comb begin
    ce[NS-1] = !v_r[NS-1] || dn_ready;
    for (int k = NS - 2; k >= 0; k--) ce[k] = !v_r[k] || ce[k+1];
  end

  assign up_ready = ce[0];
  assign dn_valid = v_r[NS-1];
  assign dn_data  = s6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (ce[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NS; k++) begin
        if (ce[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // magnitude of term
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_nxt.tneg[i] = up_data.term[i][63];
      s1_nxt.tm[i]   = 63'(up_data.term[i][63] ? 64'd0 - up_data.term[i] : up_data.term[i]);
    end
    s1_nxt.gm   = up_data.gm;
    s1_nxt.sat  = up_data.sat;
    s1_nxt.side = up_data.side;
  end

  // four partial products per axis
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_nxt.p00[i] = 64'(s1_r.gm[31:0]) * 64'(s1_r.tm[i][31:0]);
      s2_nxt.p01[i] = 63'(s1_r.gm[31:0]) * 63'(s1_r.tm[i][62:32]);
      s2_nxt.p10[i] = 48'(s1_r.gm[47:32]) * 48'(s1_r.tm[i][31:0]);
      s2_nxt.p11[i] = 47'(s1_r.gm[47:32]) * 47'(s1_r.tm[i][62:32]);
    end
    s2_nxt.tneg = s1_r.tneg;
    s2_nxt.sat  = s1_r.sat;
    s2_nxt.side = s1_r.side;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_nxt.full[i] = PW'(s2_r.p00[i]) + (PW'(s2_r.p01[i]) << 32)
                     + (PW'(s2_r.p10[i]) << 32) + (PW'(s2_r.p11[i]) << 64);
    end
    s3_nxt.tneg = s2_r.tneg;
    s3_nxt.sat  = s2_r.sat;
    s3_nxt.side = s2_r.side;
  end

  // scale down and clamp to 2^61
  always_comb begin
    logic [PW-1:0] q;
    s4_nxt.sat = s3_r.sat;
    for (int i = 0; i < 3; i++) begin
      q = s3_r.full[i] >> FRAC_BITS;
      if (q > PW'(rgf_pkg::ICAP)) begin
        s4_nxt.dm[i] = rgf_pkg::ICAP;
        s4_nxt.sat   = 1'b1;
      end else begin
        s4_nxt.dm[i] = q[61:0];
      end
    end
    s4_nxt.tneg = s3_r.tneg;
    s4_nxt.side = s3_r.side;
  end

  // add to the accumulator
  always_comb begin
    logic [63:0] delta;
    for (int i = 0; i < 3; i++) begin
      delta = s4_r.tneg[i] ? 64'd0 - 64'(s4_r.dm[i]) : 64'(s4_r.dm[i]);
      s5_nxt.sum[i] = {{16{s4_r.side.force_in[i][47]}}, s4_r.side.force_in[i]} + delta;
    end
    s5_nxt.sat  = s4_r.sat;
    s5_nxt.last = s4_r.side.last;
  end

  // saturate to 48 bits
  always_comb begin
    s6_nxt.saturated = s5_r.sat;
    for (int i = 0; i < 3; i++) begin
      if ($signed(s5_r.sum[i]) > FMAX) begin
        s6_nxt.force_out[i] = FMAX[47:0];
        s6_nxt.saturated    = 1'b1;
      end else if ($signed(s5_r.sum[i]) < FMIN) begin
        s6_nxt.force_out[i] = FMIN[47:0];
        s6_nxt.saturated    = 1'b1;
      end else begin
        s6_nxt.force_out[i] = s5_r.sum[i][47:0];
      end
    end
    s6_nxt.last = s5_r.last;
  end

  always_ff @(posedge clk) begin
    if (ce[0]) s1_r <= s1_nxt;
    if (ce[1]) s2_r <= s2_nxt;
    if (ce[2]) s3_r <= s3_nxt;
    if (ce[3]) s4_r <= s4_nxt;
    if (ce[4]) s5_r <= s5_nxt;
    if (ce[5]) s6_r <= s6_nxt;
  end

endmodule

FILE: sv/relativistic_gravity_force_unit.sv
`timescale 1ns / 1ps
// relativistic_gravity_force_unit: top level, gravity registers and the force pipeline
//
//   channel   dir   handshake      contents
//   in_chan   in    valid/ready    gbr xyz, gamma, mass, force xyz in, last_particle
//   out_chan  out   valid/ready    force xyz out, saturated, last
//   cfg_chan  in    valid/ready    register index, 32-bit gravity component
//
// one request enters per clock and one result leaves per clock when the sink keeps up;
// the pipeline is the 33-stage beta divider (one quotient bit a stage)
// followed by 3 dot-product, 3 term and 6 scaling/accumulate stages
// every stage carries its own valid bit and only moves when the stage after it is free,
// so bubbles close up behind a stalled output and nothing is dropped or repeated
// rst_n is synchronous: it clears the valid bits and the gravity registers to zero
// the register port is always ready; an index past grav_z is ignored
module relativistic_gravity_force_unit #(
  parameter int FRAC_BITS = rgf_pkg::FRAC_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  rgf_in_if.sink    in_chan,
  rgf_out_if.source out_chan,
  rgf_cfg_if.sink   cfg_chan
);

  // gravity vector, q16.16 per axis
  logic [2:0][31:0] grav_r;

  rgf_pkg::req_t      req;
  rgf_pkg::div_out_t  div_data;
  rgf_pkg::dot_out_t  dot_data;
  rgf_pkg::term_out_t term_data;
  rgf_pkg::res_t      res;

  logic div_valid, div_ready;
  logic dot_valid, dot_ready;
  logic term_valid, term_ready;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r <= '0;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        rgf_pkg::CFG_GRAV_X: grav_r[0] <= cfg_chan.data;
        rgf_pkg::CFG_GRAV_Y: grav_r[1] <= cfg_chan.data;
        rgf_pkg::CFG_GRAV_Z: grav_r[2] <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // pack the request
  always_comb begin
    req.gbr[0]           = in_chan.gbr_x;
    req.gbr[1]           = in_chan.gbr_y;
    req.gbr[2]           = in_chan.gbr_z;
    req.gamma            = in_chan.gamma;
    req.mass             = in_chan.mass;
    req.side.force_in[0] = in_chan.force_x_in;
    req.side.force_in[1] = in_chan.force_y_in;
    req.side.force_in[2] = in_chan.force_z_in;
    req.side.last        = in_chan.last_particle;
  end

  // beta = gbr / gamma, sign kept apart from the magnitude
  rgf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_chan.valid),
    .up_ready (in_chan.ready),
    .up_data  (req),
    .dn_valid (div_valid),
    .dn_ready (div_ready),
    .dn_data  (div_data)
  );

  // 1 + beta^2, beta.g and gamma*m
  rgf_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .grav     (grav_r),
    .up_valid (div_valid),
    .up_ready (div_ready),
    .up_data  (div_data),
    .dn_valid (dot_valid),
    .dn_ready (dot_ready),
    .dn_data  (dot_data)
  );

  // per-axis bracket term, products clamped to 2^61
  rgf_term #(.FRAC_BITS(FRAC_BITS)) u_term (
    .clk      (clk),
    .rst_n    (rst_n),
    .grav     (grav_r),
    .up_valid (dot_valid),
    .up_ready (dot_ready),
    .up_data  (dot_data),
    .dn_valid (term_valid),
    .dn_ready (term_ready),
    .dn_data  (term_data)
  );

  // scale by gamma*m, accumulate, saturate; last stage is the output register
  rgf_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (term_valid),
    .up_ready (term_ready),
    .up_data  (term_data),
    .dn_valid (out_chan.valid),
    .dn_ready (out_chan.ready),
    .dn_data  (res)
  );

  assign out_chan.force_x_out = res.force_out[0];
  assign out_chan.force_y_out = res.force_out[1];
  assign out_chan.force_z_out = res.force_out[2];
  assign out_chan.saturated   = res.saturated;
  assign out_chan.last        = res.last;

endmodule
